[rtl/core/zip_traditional_decrypt_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the traditional ZIP decrypt core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ZIP_TRADITIONAL_DECRYPT_CORE_ASSERT_SVH
`define ZIP_TRADITIONAL_DECRYPT_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define ZTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted
`define ZTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ZTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ZTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/zipd_pkg.sv]
// ----------------------------------------------------------------------------
// zipd_pkg
// Types, constants and the CRC-32 byte step shared by the decrypt core.
// ----------------------------------------------------------------------------
package zipd_pkg;

	localparam logic [31:0] KEY0_INIT = 32'h12345678;
	localparam logic [31:0] KEY1_INIT = 32'h23456789;
	localparam logic [31:0] KEY2_INIT = 32'h34567890;
	localparam logic [31:0] KEY_MULT  = 32'd134775813;
	localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
	localparam logic [3:0]  HDR_LEN   = 4'd12;

	// Operation codes
	localparam logic [1:0] OP_INIT     = 2'd0;
	localparam logic [1:0] OP_PASSWORD = 2'd1;
	localparam logic [1:0] OP_CIPHER   = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic       is_header;
		logic       check_done;
		logic       password_ok;
		logic       last_out;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STREAM,
		ST_KEY0,
		ST_SUM,
		ST_MUL,
		ST_KEY1,
		ST_KEY2,
		ST_DONE
	} state_t;

	// Reflected CRC-32 step over one byte, no inversion
	function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[rtl/core/zipd_mul.sv]
// ----------------------------------------------------------------------------
// zipd_mul
// Shared 32x32 multiplier, low word of the product registered.
// ----------------------------------------------------------------------------
module zipd_mul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p
);

	logic [31:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

	assign p = p_q;

endmodule

[rtl/core/zip_traditional_decrypt_core.sv]
// ----------------------------------------------------------------------------
// zip_traditional_decrypt_core
// Cipher bytes step through STREAM, KEY0, SUM, MUL, KEY1, KEY2 and DONE,
// password bytes through KEY0 to DONE, init and unused codes straight to DONE;
// the result beat is registered as the item leaves DONE. One item at a time:
// the sequencer reuses one multiplier and one CRC step, so a new item stalls
// until the last leaves DONE, also while an earlier result beat is held off.
// Reset loads the key constants, clears the header count and check byte.
// ----------------------------------------------------------------------------
`include "zip_traditional_decrypt_core_assert.svh"

module zip_traditional_decrypt_core
	import zipd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	state_t      state_q, state_nxt;
	in_item_t    item_q;
	logic [31:0] key0_q, key1_q, key2_q;
	logic [3:0]  hdr_cnt_q;
	logic [7:0]  check_q;
	logic [7:0]  plain_q;
	out_item_t   out_q;
	logic        out_valid_q;

	logic        in_acc;
	logic        out_free;
	logic        mul_en;
	logic [31:0] mul_a, mul_b, prod;
	logic [31:0] crc_in, crc_out;
	logic [7:0]  crc_byte;
	logic [7:0]  mix_byte;
	logic [15:0] ks_t;
	out_item_t   res;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	zipd_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_data.operation == OP_CIPHER) begin
						state_nxt = ST_STREAM;
					end else if (in_data.operation == OP_PASSWORD) begin
						state_nxt = ST_KEY0;
					end else begin
						state_nxt = ST_DONE;
					end
				end
			end
			ST_STREAM: state_nxt = ST_KEY0;
			ST_KEY0:   state_nxt = ST_SUM;
			ST_SUM:    state_nxt = ST_MUL;
			ST_MUL:    state_nxt = ST_KEY1;
			ST_KEY1:   state_nxt = ST_KEY2;
			ST_KEY2:   state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// operand selection for the shared multiplier and CRC step
	assign ks_t     = {key2_q[15:2], 1'b1, key2_q[0]};
	assign mix_byte = (item_q.operation == OP_CIPHER) ? (item_q.data_byte ^ prod[15:8])
	                                                  : item_q.data_byte;

	always_comb begin
		mul_en   = 1'b0;
		mul_a    = key1_q;
		mul_b    = KEY_MULT;
		crc_in   = key0_q;
		crc_byte = mix_byte;
		unique case (state_q)
			ST_STREAM: begin
				mul_en = 1'b1;
				mul_a  = {16'd0, ks_t};
				mul_b  = {16'd0, ks_t ^ 16'd1};
			end
			ST_MUL: begin
				mul_en = 1'b1;
			end
			ST_KEY2: begin
				crc_in   = key2_q;
				crc_byte = key1_q[31:24];
			end
			default: begin
			end
		endcase
	end

	assign crc_out = crc_step(crc_in, crc_byte);

	// result beat
	always_comb begin
		res = '0;
		if (item_q.operation == OP_CIPHER) begin
			res.plain_byte = plain_q;
			res.last_out   = item_q.last;
			if (hdr_cnt_q < HDR_LEN) begin
				res.is_header = 1'b1;
				if (hdr_cnt_q == HDR_LEN - 4'd1) begin
					res.check_done  = 1'b1;
					res.password_ok = (plain_q == check_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key0_q      <= KEY0_INIT;
			key1_q      <= KEY1_INIT;
			key2_q      <= KEY2_INIT;
			hdr_cnt_q   <= '0;
			check_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				check_q <= cfg_wr_data;
			end
			if (in_acc && in_data.operation == OP_INIT) begin
				key0_q    <= KEY0_INIT;
				key1_q    <= KEY1_INIT;
				key2_q    <= KEY2_INIT;
				hdr_cnt_q <= '0;
			end
			case (state_q)
				ST_KEY0: key0_q <= crc_out;
				ST_SUM:  key1_q <= key1_q + {24'd0, key0_q[7:0]};
				ST_KEY1: key1_q <= prod + 32'd1;
				ST_KEY2: key2_q <= crc_out;
				default: begin
				end
			endcase
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				// advance the header count, saturating after the check byte
				if (item_q.operation == OP_CIPHER && hdr_cnt_q < HDR_LEN) begin
					hdr_cnt_q <= hdr_cnt_q + 4'd1;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
		end
		if (state_q == ST_KEY0) begin
			plain_q <= mix_byte;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ZTD_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`ZTD_ASSERT_IMP(a_hdr_cnt_range, clk, arst_n, 1'b1, hdr_cnt_q <= HDR_LEN)
	`ZTD_ASSERT_IMP(a_check_in_header, clk, arst_n, out_valid && out_data.check_done, out_data.is_header)
	`ZTD_ASSERT_IMP(a_ok_needs_check, clk, arst_n, out_valid && out_data.password_ok, out_data.check_done)

endmodule
